>>> src/mps_pkg.sv
`default_nettype none
package mps_pkg;
  localparam int unsigned ID_W  = 20;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned IN_W  = 32;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_OUTER,
    ST_FEED,
    ST_DRAIN,
    ST_PICK,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
  } tag_t;
endpackage
`default_nettype wire

>>> src/mps_if.sv
`default_nettype none
interface mps_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [mps_pkg::IN_W-1:0] point_x;
  logic signed [mps_pkg::IN_W-1:0] point_y;
  logic [mps_pkg::ID_W-1:0]        point_id;
  logic                            last_point;
  modport source (output valid, point_x, point_y, point_id, last_point, input ready);
  modport sink (input valid, point_x, point_y, point_id, last_point, output ready);
endinterface

interface mps_out_if;
  logic                       valid;
  logic                       ready;
  logic [mps_pkg::ID_W-1:0]   best_id;
  logic [mps_pkg::SUM_W-1:0]  best_sum;
  logic                       found;
  modport source (output valid, best_id, best_sum, found, input ready);
  modport sink (input valid, best_id, best_sum, found, output ready);
endinterface
`default_nettype wire

>>> src/medoid_point_select.sv
`default_nettype none
// channel | dir | word
// in_if   | in  | point_x, point_y, point_id, last_point
// out_if  | out | best_id, best_sum, found
//
// loading takes one cycle a word; on a last word each stored point i in turn
// streams all n stored points j, one pair a cycle, into a two-stage squaring
// front end and a chain of COORD_BITS+2 root cells
// each point i passes through issue, n feeds, chain drain and pick in turn,
// so a set is searched point by point through the one-pair-a-cycle feed
// reset empties the set; input is held off during the search and while the
// result waits to be taken
module medoid_point_select #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned COORD_BITS = 32
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  mps_in_if.sink   in_if,
  mps_out_if.source out_if
);
  import mps_pkg::*;
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = COORD_BITS;

  state_e state_q, state_d;
  logic [AW:0]   cnt_q, i_q, j_q;
  logic [SUM_W-1:0] sum_q, best_sum_q, out_sum;
  logic [ID_W-1:0]  best_id_q, out_id;
  logic             out_found;

  // point store
  logic signed [CW-1:0] xs [MAX_POINTS];
  logic signed [CW-1:0] ys [MAX_POINTS];
  logic [ID_W-1:0]      ids [MAX_POINTS];
  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;
  logic [ID_W-1:0]      aid_q;

  logic acc, rd_b;
  tag_t tag_b_q, tag_c;
  logic [CW+1:0] pair_dist;
  logic [SUM_W:0] sum_add;

  assign acc = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == ST_LOAD);
  assign rd_b = (state_q == ST_FEED);

  always_ff @(posedge clk_i) begin
    if (acc && cnt_q < (AW+1)'(MAX_POINTS)) begin
      xs[cnt_q[AW-1:0]]  <= in_if.point_x[CW-1:0];
      ys[cnt_q[AW-1:0]]  <= in_if.point_y[CW-1:0];
      ids[cnt_q[AW-1:0]] <= in_if.point_id;
    end
    // outer point read (one port), inner point read (other port)
    ax_q  <= xs[i_q[AW-1:0]];
    ay_q  <= ys[i_q[AW-1:0]];
    aid_q <= ids[i_q[AW-1:0]];
    bx_q  <= xs[j_q[AW-1:0]];
    by_q  <= ys[j_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_b_q <= '0;
    end else begin
      tag_b_q <= '{valid: rd_b, first: rd_b && (j_q == '0),
                   last: rd_b && (j_q == cnt_q - 1'b1)};
    end
  end

  mps_dist_chain #(.CW(CW)) u_chain (
    .clk_i, .rst_ni, .tag_i(tag_b_q),
    .ax_i(ax_q), .ay_i(ay_q), .bx_i(bx_q), .by_i(by_q),
    .tag_o(tag_c), .dist_o(pair_dist)
  );

  assign sum_add = (tag_c.first ? '0 : {1'b0, sum_q}) + (SUM_W+1)'(pair_dist);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:  if (acc && in_if.last_point) state_d = (cnt_q == '0 &&
                  MAX_POINTS == 0) ? ST_OUT : ST_OUTER;
      ST_OUTER: state_d = ST_FEED;
      ST_FEED:  if (j_q == cnt_q - 1'b1) state_d = ST_DRAIN;
      ST_DRAIN: if (tag_c.valid && tag_c.last) state_d = ST_PICK;
      ST_PICK:  state_d = (i_q == cnt_q - 1'b1) ? ST_OUT : ST_OUTER;
      ST_OUT:   if (out_if.ready) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      best_sum_q <= SUM_MAX;
      best_id_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_LOAD: begin
          if (acc && cnt_q < (AW+1)'(MAX_POINTS)) cnt_q <= cnt_q + 1'b1;
          i_q <= '0;
          j_q <= '0;
        end
        ST_FEED: if (j_q != cnt_q - 1'b1) j_q <= j_q + 1'b1;
        ST_PICK: begin
          if (i_q == '0 || sum_q < best_sum_q) begin
            best_sum_q <= sum_q;
            best_id_q  <= aid_q;
          end
          i_q <= i_q + 1'b1;
          j_q <= '0;
        end
        ST_OUT: if (out_if.ready) begin
          cnt_q      <= '0;
          best_sum_q <= SUM_MAX;
          best_id_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  // distance accumulator, saturating
  always_ff @(posedge clk_i) begin
    if (tag_c.valid) sum_q <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
  end

  // result word, held steady by the best registers while it waits
  always_comb begin
    out_found = (cnt_q != '0);
    out_id    = out_found ? best_id_q : '0;
    out_sum   = out_found ? best_sum_q : '0;
  end

  assign out_if.valid    = (state_q == ST_OUT);
  assign out_if.best_id  = out_id;
  assign out_if.best_sum = out_sum;
  assign out_if.found    = out_found;

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> !in_if.ready) else $error("input taken while busy");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(MAX_POINTS)) else $error("point count overflow");
  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready) |=> (cnt_q == '0 && best_sum_q == SUM_MAX))
    else $error("set not cleared after result");
endmodule
`default_nettype wire

>>> src/mps_sqrt_cell.sv
`default_nettype none
// one restoring square root step; remainder and root hop one cell per cycle
module mps_sqrt_cell #(
  parameter int unsigned RW   = 36,
  parameter int unsigned QW   = 34,
  parameter int unsigned STEP = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mps_pkg::tag_t     tag_i,
  input  wire logic [2*QW-1:0]   rad_i,
  input  wire logic [RW-1:0]     rem_i,
  input  wire logic [QW-1:0]     root_i,
  output      mps_pkg::tag_t     tag_o,
  output      logic [2*QW-1:0]   rad_o,
  output      logic [RW-1:0]     rem_o,
  output      logic [QW-1:0]     root_o
);
  import mps_pkg::*;
  logic [RW-1:0] rem_sh, trial;
  logic [QW-1:0] root_d;
  logic [RW-1:0] rem_d;
  tag_t          tag_q;
  logic [2*QW-1:0] rad_q;
  logic [RW-1:0] rem_q;
  logic [QW-1:0] root_q;

  always_comb begin
    rem_sh = {rem_i[RW-3:0], rad_i[2*QW-1-2*STEP -: 2]};
    trial  = {root_i[RW-3:0], 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_i[QW-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_i;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign tag_o  = tag_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

>>> src/mps_dist_chain.sv
`default_nettype none
// squared-distance front end then a chain of root cells, one pair per cycle
module mps_dist_chain #(
  parameter int unsigned CW = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mps_pkg::tag_t          tag_i,
  input  wire logic signed [CW-1:0]   ax_i,
  input  wire logic signed [CW-1:0]   ay_i,
  input  wire logic signed [CW-1:0]   bx_i,
  input  wire logic signed [CW-1:0]   by_i,
  output      mps_pkg::tag_t          tag_o,
  output      logic [CW+1:0]          dist_o
);
  import mps_pkg::*;
  localparam int unsigned QW = CW + 2;
  localparam int unsigned RW = QW + 2;

  tag_t          t1_q, t2_q;
  logic [CW:0]   mx_q, my_q;
  logic [2*CW+1:0] sx_q, sy_q;
  logic signed [CW:0] dx, dy;

  assign dx = $signed({ax_i[CW-1], ax_i}) - $signed({bx_i[CW-1], bx_i});
  assign dy = $signed({ay_i[CW-1], ay_i}) - $signed({by_i[CW-1], by_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
    end else begin
      t1_q <= tag_i;
      t2_q <= t1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= dx[CW] ? (CW+1)'(-dx) : dx;
    my_q <= dy[CW] ? (CW+1)'(-dy) : dy;
    sx_q <= mx_q * mx_q;
    sy_q <= my_q * my_q;
  end

  tag_t            tg [QW+1];
  logic [2*QW-1:0] rd [QW+1];
  logic [RW-1:0]   rm [QW+1];
  logic [QW-1:0]   rt [QW+1];

  assign tg[0] = t2_q;
  assign rd[0] = (2*QW)'({1'b0, sx_q} + {1'b0, sy_q});
  assign rm[0] = '0;
  assign rt[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    mps_sqrt_cell #(.RW(RW), .QW(QW), .STEP(k)) u_cell (
      .clk_i, .rst_ni,
      .tag_i(tg[k]), .rad_i(rd[k]), .rem_i(rm[k]), .root_i(rt[k]),
      .tag_o(tg[k+1]), .rad_o(rd[k+1]), .rem_o(rm[k+1]), .root_o(rt[k+1])
    );
  end

  assign tag_o  = tg[QW];
  assign dist_o = rt[QW];
endmodule
`default_nettype wire

>>> tb/sv/tb_medoid_point_select.sv
`default_nettype none
module tb_medoid_point_select;
  timeunit 1ns;
  timeprecision 1ps;
  import mps_pkg::*;

  localparam int unsigned MAX_PTS  = 256;
  localparam int unsigned HANG_MAX = 2000000;  // cycles with no accepted word

  typedef struct {
    logic [ID_W-1:0]  best_id;
    logic [SUM_W-1:0] best_sum;
    logic             found;
  } medoid_t;

  // keeps the current set, predicts the medoid when the set closes
  class medoid_board;
    logic signed [IN_W-1:0] xs[$];
    logic signed [IN_W-1:0] ys[$];
    logic [ID_W-1:0]        ids[$];
    medoid_t                awaited[$];
    int                     fails;
    int                     sets_done;

    function logic [33:0] root_floor(logic [65:0] v);
      logic [33:0] r;
      logic [33:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
        c = r | (34'd1 << b);
        if ({34'd0, c} * {34'd0, c} <= {2'd0, v}) r = c;
      end
      return r;
    endfunction

    function logic [33:0] span(int a, int b);
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [65:0]        q;
      dx = 33'(xs[a]) - 33'(xs[b]);
      dy = 33'(ys[a]) - 33'(ys[b]);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      q = 66'(unsigned'(dx)) * 66'(unsigned'(dx)) + 66'(unsigned'(dy)) * 66'(unsigned'(dy));
      return root_floor(q);
    endfunction

    function void note_point(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                             logic [ID_W-1:0] id, logic last);
      medoid_t     m;
      logic [55:0] s;
      // points past the store size are dropped
      if (xs.size() < MAX_PTS) begin
        xs.push_back(x);
        ys.push_back(y);
        ids.push_back(id);
      end
      if (!last) return;
      m.best_id  = '0;
      m.best_sum = SUM_MAX;
      for (int i = 0; i < xs.size(); i++) begin
        s = '0;
        for (int j = 0; j < xs.size(); j++) begin
          s = s + 56'(span(i, j));
          if (s > 56'(SUM_MAX)) s = 56'(SUM_MAX);
        end
        // earliest point wins a tie
        if (i == 0 || s[SUM_W-1:0] < m.best_sum) begin
          m.best_sum = s[SUM_W-1:0];
          m.best_id  = ids[i];
        end
      end
      m.found = (xs.size() > 0);
      if (!m.found) begin
        m.best_id  = '0;
        m.best_sum = '0;
      end
      awaited.push_back(m);
      xs.delete();
      ys.delete();
      ids.delete();
    endfunction

    function void check_result(logic [ID_W-1:0] id, logic [SUM_W-1:0] sum, logic fnd);
      medoid_t m;
      if (awaited.size() == 0) begin
        $error("unexpected result word: best_id %0d best_sum %0d found %0d", id, sum, fnd);
        fails++;
        return;
      end
      m = awaited.pop_front();
      sets_done++;
      if (id !== m.best_id) begin
        $error("best_id: expected %0d, got %0d", m.best_id, id);
        fails++;
      end
      if (sum !== m.best_sum) begin
        $error("best_sum: expected %0d, got %0d", m.best_sum, sum);
        fails++;
      end
      if (fnd !== m.found) begin
        $error("found: expected %0d, got %0d", m.found, fnd);
        fails++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mps_in_if  in_if ();
  mps_out_if out_if ();

  medoid_point_select u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #2 clk_i = ~clk_i;

  medoid_board board = new();
  bit          no_idle;        // stretch with no gaps on either side
  int          words_sent;
  int          hang_count = 0;

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 18));
  endfunction

  // one point word, with a random gap ahead of it
  task automatic send_point(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                            logic [ID_W-1:0] id, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.point_x    <= x;
    in_if.point_y    <= y;
    in_if.point_id   <= id;
    in_if.last_point <= last;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_point(x, y, id, last);
    words_sent++;
  endtask

  // hold the sender until every awaited medoid is back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [IN_W-1:0] pick_coord(int mode);
    case (mode)
      0: return $signed($urandom());
      1: return IN_W'($signed($urandom_range(0, 4000)) - 2000) <<< 16;
      default: return IN_W'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  // random set of n words; the final word closes the set
  task automatic send_set(int n);
    int mode;
    mode = $urandom_range(0, 2);
    for (int k = 0; k < n; k++)
      send_point(pick_coord(mode), pick_coord(mode), ID_W'($urandom()), k == n - 1);
  endtask

  // result side: random stalls, check every word taken
  initial begin
    int gap;
    out_if.ready = 1'b0;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      board.check_result(out_if.best_id, out_if.best_sum, out_if.found);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      hang_count <= 0;
    end else begin
      hang_count <= hang_count + 1;
      if (hang_count >= HANG_MAX) begin
        $display("timeout: no word moved for %0d cycles", HANG_MAX);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int n;
    in_if.valid      = 1'b0;
    in_if.point_x    = '0;
    in_if.point_y    = '0;
    in_if.point_id   = '0;
    in_if.last_point = 1'b0;
    words_sent = 0;
    no_idle    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: lone point gives sum zero
    send_point('0, '0, '0, 1'b1);
    // opposite extremes, id extremes
    send_point(32'sh8000_0000, 32'sh8000_0000, '0, 1'b0);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, {ID_W{1'b1}}, 1'b1);
    // symmetric pair and triple: tie goes to the earliest point
    send_point(32'sh0001_0000, '0, 20'd5, 1'b0);
    send_point(-32'sh0001_0000, '0, 20'd6, 1'b1);
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 20'd7, 1'b0);
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 20'd8, 1'b0);
    send_point(32'sh0000_0000, 32'sh0000_0000, 20'd9, 1'b1);
    // duplicate ids and coincident points
    send_point(32'sh0003_8000, 32'shfffc_0000, 20'd3, 1'b0);
    send_point(32'sh0003_8000, 32'shfffc_0000, 20'd3, 1'b0);
    send_point(32'sh0005_0000, 32'sh0002_0000, 20'd3, 1'b1);
    // equal distances on a square with a centre point last
    send_point(32'sh0010_0000, 32'sh0010_0000, 20'd11, 1'b0);
    send_point(-32'sh0010_0000, 32'sh0010_0000, 20'd12, 1'b0);
    send_point(32'sh0010_0000, -32'sh0010_0000, 20'd13, 1'b0);
    send_point(-32'sh0010_0000, -32'sh0010_0000, 20'd14, 1'b0);
    send_point('0, '0, 20'd15, 1'b1);
    wait_drained();

    // a full store, then an overrun set whose closing word is dropped
    send_set(MAX_PTS);
    wait_drained();
    send_set(MAX_PTS + 3);
    wait_drained();

    // random sets, mostly small
    while (words_sent < 1950) begin
      no_idle = ($urandom_range(0, 3) == 0);
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      send_set(n);
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("covered %0d point words in %0d sets: extremes, ties, duplicates, full and overrun stores",
             words_sent, board.sets_done);
    if (board.fails == 0 && board.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", board.fails, board.awaited.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
